>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the core RTL.
// Each macro expects clk and rst to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/c8x_pkg.sv
package c8x_pkg;

  // Program counter and register file geometry
  localparam int PC_W      = 12;
  localparam int REG_COUNT = 16;
  localparam int REG_AW    = 4;
  localparam int REG_W     = 8;

  localparam logic [PC_W-1:0] PC_STEP = 12'd2;

  // Opcode groups (top nibble)
  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SE   = 4'h3;
  localparam logic [3:0] GRP_SNE  = 4'h4;
  localparam logic [3:0] GRP_SEXY = 4'h5;
  localparam logic [3:0] GRP_LD   = 4'h6;
  localparam logic [3:0] GRP_ADD  = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;

  // Register-register operations (low nibble of group 8)
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;

  // Full system opcodes
  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  // One result word
  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    logic              clear_display;
    logic              skipped;
    logic              reg_write;
    logic [REG_AW-1:0] reg_index;
    logic [REG_W-1:0]  reg_value;
    logic              stack_fault;
    logic              unsupported;
  } res_t;

  // Return stack requests
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

endpackage

>>> rtl/core/c8x_ram.sv
module c8x_ram
  #(parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1)
  (input  logic             clk,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/c8x_regs.sv
module c8x_regs
  import c8x_pkg::*;
  (input  logic              clk,
   input  logic              rst,
   input  logic [REG_AW-1:0] raddr_x,
   input  logic [REG_AW-1:0] raddr_y,
   input  logic              we,
   input  logic [REG_AW-1:0] waddr,
   input  logic [REG_W-1:0]  wdata,
   output logic [REG_W-1:0]  rdata_x,
   output logic [REG_W-1:0]  rdata_y);

  logic [REG_COUNT-1:0] valid;
  logic [REG_W-1:0]     ram_x;
  logic [REG_W-1:0]     ram_y;
  logic                 vld_x;
  logic                 vld_y;
  logic                 byp_x;
  logic                 byp_y;
  logic [REG_W-1:0]     byp_val;

  // Two copies give two read ports
  c8x_ram #(.WIDTH(REG_W), .DEPTH(REG_COUNT)) u_ram_x (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr_x), .rdata(ram_x));

  c8x_ram #(.WIDTH(REG_W), .DEPTH(REG_COUNT)) u_ram_y (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr_y), .rdata(ram_y));

  // Track written entries; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // Align valid bits and same-edge write forwarding with the read data
  always_ff @(posedge clk) begin
    vld_x   <= valid[raddr_x];
    vld_y   <= valid[raddr_y];
    byp_x   <= we && (waddr == raddr_x);
    byp_y   <= we && (waddr == raddr_y);
    byp_val <= wdata;
  end

  assign rdata_x = byp_x ? byp_val : (vld_x ? ram_x : '0);
  assign rdata_y = byp_y ? byp_val : (vld_y ? ram_y : '0);

endmodule

>>> rtl/core/c8x_stack.sv
module c8x_stack
  import c8x_pkg::*;
  #(parameter int STACK_DEPTH = 16,
    localparam int LW = $clog2(STACK_DEPTH + 1),
    localparam int AW = $clog2(STACK_DEPTH))
  (input  logic            clk,
   input  logic            rst,
   input  stk_ctl_t        ctl,
   input  logic [PC_W-1:0] push_data,
   output logic [LW-1:0]   level,
   output logic [PC_W-1:0] top);

  logic [LW-1:0]   level_next;
  logic [LW-1:0]   rd_level;
  logic [PC_W-1:0] below;

  // Next fill level
  always_comb begin
    level_next = level;
    if (ctl.push) begin
      level_next = level + LW'(1);
    end else if (ctl.pop) begin
      level_next = level - LW'(1);
    end
  end

  // Prefetch the entry under the new top, ready for a pop next cycle
  assign rd_level = level_next - LW'(2);

  c8x_ram #(.WIDTH(PC_W), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .we(ctl.push), .waddr(level[AW-1:0]), .wdata(push_data),
    .raddr(rd_level[AW-1:0]), .rdata(below));

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else begin
      level <= level_next;
    end
  end

  // Hold the top entry in a register
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      top <= push_data;
    end else if (ctl.pop) begin
      top <= below;
    end
  end

endmodule

>>> rtl/core/c8x_exec.sv
module c8x_exec
  import c8x_pkg::*;
  #(parameter int STACK_DEPTH = 16,
    localparam int LW = $clog2(STACK_DEPTH + 1))
  (input  logic [15:0]     instr,
   input  logic [PC_W-1:0] pc,
   input  logic [LW-1:0]   level,
   input  logic [PC_W-1:0] top,
   input  logic [REG_W-1:0] vx,
   input  logic [REG_W-1:0] vy,
   output res_t            res,
   output stk_ctl_t        ctl);

  logic [3:0]        grp;
  logic [3:0]        n;
  logic [REG_W-1:0]  kk;
  logic [PC_W-1:0]   nnn;
  logic [PC_W-1:0]   npc;
  logic              bad;
  logic              fault;

  assign grp = instr[15:12];
  assign n   = instr[3:0];
  assign kk  = instr[7:0];
  assign nnn = instr[11:0];

  // Decode and execute one instruction word
  always_comb begin
    res   = '0;
    ctl   = '0;
    bad   = 1'b0;
    fault = 1'b0;
    npc   = pc + PC_STEP;
    unique case (grp)
      GRP_SYS: begin
        if (instr == OP_CLS) begin
          res.clear_display = 1'b1;
        end else if (instr == OP_RET) begin
          if (level == '0) begin
            fault = 1'b1;
          end else begin
            ctl.pop = 1'b1;
            npc     = top;
          end
        end else begin
          bad = 1'b1;
        end
      end
      GRP_JP: begin
        npc = nnn;
      end
      GRP_CALL: begin
        if (level >= LW'(STACK_DEPTH)) begin
          fault = 1'b1;
        end else begin
          ctl.push = 1'b1;
          npc      = nnn;
        end
      end
      GRP_SE: begin
        res.skipped = (vx == kk);
      end
      GRP_SNE: begin
        res.skipped = (vx != kk);
      end
      GRP_SEXY: begin
        if (n != 4'h0) begin
          bad = 1'b1;
        end else begin
          res.skipped = (vx == vy);
        end
      end
      GRP_LD: begin
        res.reg_write = 1'b1;
        res.reg_index = instr[11:8];
        res.reg_value = kk;
      end
      GRP_ADD: begin
        res.reg_write = 1'b1;
        res.reg_index = instr[11:8];
        res.reg_value = vx + kk;
      end
      GRP_ALU: begin
        res.reg_write = 1'b1;
        res.reg_index = instr[11:8];
        unique case (n)
          ALU_MOV: res.reg_value = vy;
          ALU_OR:  res.reg_value = vx | vy;
          ALU_AND: res.reg_value = vx & vy;
          ALU_XOR: res.reg_value = vx ^ vy;
          default: begin
            res.reg_write = 1'b0;
            res.reg_index = '0;
            bad           = 1'b1;
          end
        endcase
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    // Faults and unsupported words leave the pc where it was
    if (bad || fault) begin
      npc = pc;
    end else if (res.skipped) begin
      npc = npc + PC_STEP;
    end
    res.next_pc     = npc;
    res.stack_fault = fault;
    res.unsupported = bad;
  end

endmodule

>>> rtl/core/chip8_execute_subset_core.sv
// Flow: a word accepted into the input register is executed once the result register is
// free or draining, and its result word is then loaded into the result register.
// Throughput: one instruction per cycle while m_tready holds; the input register, the decode and
// execute logic and the result register form the only path, with state updates
// (pc, registers, return stack) taken at the same edge as the result register.
// Reset (rst, synchronous): pc to START_PC, registers read as zero, stack empty.
`include "assert_macros.svh"

module chip8_execute_subset_core
  import c8x_pkg::*;
  #(parameter int STACK_DEPTH = 16,
    parameter int START_PC    = 512)
  (input  logic        clk,
   input  logic        rst,
   input  logic        s_tvalid,
   output logic        s_tready,
   input  logic [15:0] s_tdata,   // instruction[15:0]
   output logic        m_tvalid,
   input  logic        m_tready,
   // next_pc[11:0], clear_display[12], skipped[13], reg_write[14],
   // reg_index[18:15], reg_value[26:19], stack_fault[27], unsupported[28], zero[31:29]
   output logic [31:0] m_tdata);

  localparam int LW = $clog2(STACK_DEPTH + 1);

  logic              s_acc;
  logic              fire;
  logic              iv;
  logic [15:0]       ir;
  logic              ov;
  res_t              ores;
  res_t              res;
  stk_ctl_t          ctl;
  stk_ctl_t          stk_ctl;
  logic [PC_W-1:0]   pc;
  logic [LW-1:0]     level;
  logic [PC_W-1:0]   top;
  logic [REG_AW-1:0] rx;
  logic [REG_AW-1:0] ry;
  logic [REG_W-1:0]  vx;
  logic [REG_W-1:0]  vy;

  // Handshake: execute when the result register is free or draining
  assign fire     = iv && (!ov || m_tready);
  assign s_tready = !iv || fire;
  assign s_acc    = s_tvalid && s_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (s_acc) begin
      iv <= 1'b1;
    end else if (fire) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      ir <= s_tdata;
    end
  end

  // Read operands for the word that will sit in the input register
  assign rx = s_acc ? s_tdata[11:8] : ir[11:8];
  assign ry = s_acc ? s_tdata[7:4]  : ir[7:4];

  c8x_regs u_regs (
    .clk(clk), .rst(rst), .raddr_x(rx), .raddr_y(ry),
    .we(fire && res.reg_write), .waddr(res.reg_index), .wdata(res.reg_value),
    .rdata_x(vx), .rdata_y(vy));

  assign stk_ctl.push = fire && ctl.push;
  assign stk_ctl.pop  = fire && ctl.pop;

  c8x_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .rst(rst), .ctl(stk_ctl), .push_data(pc + PC_STEP),
    .level(level), .top(top));

  c8x_exec #(.STACK_DEPTH(STACK_DEPTH)) u_exec (
    .instr(ir), .pc(pc), .level(level), .top(top), .vx(vx), .vy(vy),
    .res(res), .ctl(ctl));

  // Program counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_W'(START_PC);
    end else if (fire) begin
      pc <= res.next_pc;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (fire) begin
      ov <= 1'b1;
    end else if (m_tready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ores <= res;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {3'b000, ores.unsupported, ores.stack_fault, ores.reg_value,
                     ores.reg_index, ores.reg_write, ores.skipped,
                     ores.clear_display, ores.next_pc};

  // Checks
  `ASSERT_CLK(a_fault_holds_pc, (m_tvalid && (ores.stack_fault || ores.unsupported)) |-> (ores.next_pc == pc), "faulting word moved the pc")
  `ASSERT_CLK(a_level_bound, level <= LW'(STACK_DEPTH), "stack level beyond depth")
  `ASSERT_CLK(a_no_write_zero, (m_tvalid && !ores.reg_write) |-> (ores.reg_index == '0 && ores.reg_value == '0), "write fields set without a write")
  `ASSERT_ALWAYS(a_reset_pc, $past(rst) |-> (pc == PC_W'(START_PC) && level == '0), "reset state wrong")

endmodule
